@@ hdl/twm_pkg.sv @@
// ----------------------------------------------------------------------------
// twm_pkg
// Shared types and constants of the thresholded window-mean filter.
// ----------------------------------------------------------------------------
package twm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 8;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int RAD_W      = 4;
  localparam int THR_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [FW_W-1:0]  FW_RESET  = FW_W'(720);
  localparam logic [FH_W-1:0]  FH_RESET  = FH_W'(576);
  localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(2);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_WINDOW_RADIUS,
    CFG_DIFF_THRESHOLD
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_CTR,
    TAG_WIN,
    TAG_NBR
  } tag_e;

  typedef enum logic [2:0] {
    A_HOLD,
    A_WIN,
    A_NBR,
    A_STEP,
    A_ROWW,
    A_ROWN
  } addr_op_e;

  typedef enum logic [1:0] {
    RES_C,
    RES_N,
    RES_D
  } res_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CTR,
    ST_CWAIT,
    ST_WIN,
    ST_WDRAIN,
    ST_DECIDE,
    ST_NBR,
    ST_NDRAIN,
    ST_DIV,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic     push;
    logic     emit;
    tag_e     rd_tag;
    addr_op_e addr_op;
    logic     nsum_init;
    logic     div_start;
    logic     div_step;
    logic     load_out;
    res_e     res_sel;
  } cmd_t;

  typedef struct packed {
    logic held_nz;
    logic full;
    logic interior;
    logic use_mean;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/twm_ctrl.sv @@
// ----------------------------------------------------------------------------
// twm_ctrl
// Sequencer: walks the window, the 3x3 fallback and the divider steps.
// ----------------------------------------------------------------------------
module twm_ctrl #(
  parameter int SW         = 5,
  parameter int DIV_N      = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_op_i,
  output logic             in_stall_o,
  input  logic [SW-1:0]    span_i,
  input  twm_pkg::sts_t    sts_i,
  output twm_pkg::cmd_t    cmd_o
);
  import twm_pkg::*;

  localparam int DC_W = $clog2(DIV_N + 1);

  st_e            st_q, st_d;
  logic           flush_q, flush_d;
  logic           win_q, win_d;
  logic [SW-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic [DC_W-1:0] dc_q, dc_d;
  res_e           sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      flush_q <= 1'b0;
      win_q   <= 1'b0;
      dx_q    <= '0;
      dy_q    <= '0;
      dc_q    <= '0;
      sel_q   <= RES_C;
    end else begin
      st_q    <= st_d;
      flush_q <= flush_d;
      win_q   <= win_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      dc_q    <= dc_d;
      sel_q   <= sel_d;
    end
  end

  // next state and counters
  always_comb begin
    st_d    = st_q;
    flush_d = flush_q;
    win_d   = win_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    dc_d    = dc_q;
    sel_d   = sel_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          flush_d = in_op_i;
          st_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (flush_q ? sts_i.held_nz : sts_i.full) begin
          win_d = sts_i.interior && sts_i.full;
          st_d  = ST_CTR;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_CTR: begin
        dx_d = '0;
        dy_d = '0;
        st_d = win_q ? ST_WIN : ST_CWAIT;
      end
      ST_CWAIT: begin
        sel_d = RES_C;
        st_d  = ST_OUT;
      end
      ST_WIN: begin
        if (dx_q == span_i) begin
          dx_d = '0;
          if (dy_q == span_i) st_d = ST_WDRAIN;
          else dy_d = dy_q + SW'(1);
        end else begin
          dx_d = dx_q + SW'(1);
        end
      end
      ST_WDRAIN: st_d = ST_DECIDE;
      ST_DECIDE: begin
        dx_d = '0;
        dy_d = '0;
        dc_d = '0;
        st_d = sts_i.use_mean ? ST_DIV : ST_NBR;
      end
      ST_NBR: begin
        if (dx_q == SW'(2)) begin
          dx_d = '0;
          if (dy_q == SW'(2)) st_d = ST_NDRAIN;
          else dy_d = dy_q + SW'(1);
        end else begin
          dx_d = dx_q + SW'(1);
        end
      end
      ST_NDRAIN: begin
        sel_d = RES_N;
        st_d  = ST_OUT;
      end
      ST_DIV: begin
        dc_d = dc_q + DC_W'(1);
        if (dc_q == DC_W'(DIV_N - 1)) begin
          sel_d = RES_D;
          st_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.rd_tag    = TAG_NONE;
    cmd_o.addr_op   = A_HOLD;
    cmd_o.res_sel   = sel_q;
    in_stall_o      = (st_q != ST_IDLE);
    unique case (st_q)
      ST_IDLE:   cmd_o.push = in_valid_i && !in_op_i;
      ST_EVAL:   cmd_o.emit = flush_q ? sts_i.held_nz : sts_i.full;
      ST_CTR: begin
        cmd_o.rd_tag  = TAG_CTR;
        cmd_o.addr_op = win_q ? A_WIN : A_HOLD;
      end
      ST_WIN: begin
        cmd_o.rd_tag  = TAG_WIN;
        cmd_o.addr_op = (dx_q == span_i) ? A_ROWW : A_STEP;
      end
      ST_DECIDE: begin
        cmd_o.div_start = sts_i.use_mean;
        cmd_o.nsum_init = !sts_i.use_mean;
        cmd_o.addr_op   = sts_i.use_mean ? A_HOLD : A_NBR;
      end
      ST_NBR: begin
        cmd_o.rd_tag  = (dx_q == SW'(1) && dy_q == SW'(1)) ? TAG_NONE : TAG_NBR;
        cmd_o.addr_op = (dx_q == SW'(2)) ? A_ROWN : A_STEP;
      end
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_OUT:    cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ hdl/twm_dp.sv @@
// ----------------------------------------------------------------------------
// twm_dp
// Datapath: registers, ring line store, window sums, 3x3 sum, divider.
// ----------------------------------------------------------------------------
module twm_dp #(
  parameter int MAX_WIDTH  = twm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = twm_pkg::MAX_RADIUS_DEF,
  parameter int SW         = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [twm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [twm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [twm_pkg::PIX_W-1:0]          sample_i,
  input  logic                               out_stall_i,
  input  twm_pkg::cmd_t                      cmd_i,
  output twm_pkg::sts_t                      sts_o,
  output logic [SW-1:0]                      span_o,
  output logic                               out_valid_o,
  output logic [twm_pkg::PIX_W-1:0]          pixel_out_o,
  output logic                               frame_last_o
);
  import twm_pkg::*;

  localparam int RING     = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int AW       = $clog2(RING);
  localparam int EW       = $clog2(MAX_WIDTH + 1);
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int RW       = $clog2(MAX_RADIUS + 1);
  localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int CNT_W    = $clog2(SIDE_MAX * SIDE_MAX + 1);
  localparam int SUM_W    = $clog2(255 * SIDE_MAX * SIDE_MAX + 1);

  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(RING)) s = s - (AW+1)'(RING);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (s[AW]) s = s + (AW+1)'(RING);
    return s[AW-1:0];
  endfunction

  // configuration
  logic [FW_W-1:0]  fw_q;
  logic [FH_W-1:0]  fh_q;
  logic [RAD_W-1:0] rad_q;
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= FW_RESET;
      fh_q  <= FH_RESET;
      rad_q <= RAD_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:    fw_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT:   fh_q  <= cfg_data_i[FH_W-1:0];
        CFG_WINDOW_RADIUS:  rad_q <= cfg_data_i[RAD_W-1:0];
        CFG_DIFF_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0]    eff_w;
  logic [FH_W-1:0]  eff_h;
  logic [RW-1:0]    eff_r;
  logic [AW-1:0]    lag;
  logic [CNT_W-1:0] min_cnt;
  int               side;

  always_comb begin
    if (fw_q == '0) eff_w = EW'(1);
    else if (32'(fw_q) > 32'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
    else eff_w = EW'(fw_q);
    eff_h = (fh_q == '0) ? FH_W'(1) : fh_q;
    if (rad_q == '0) eff_r = RW'(1);
    else if (32'(rad_q) > 32'(MAX_RADIUS)) eff_r = RW'(MAX_RADIUS);
    else eff_r = RW'(rad_q);
    lag     = AW'(32'(eff_r) * 32'(eff_w) + 32'(eff_r));
    side    = 2 * int'(32'(eff_r)) + 1;
    // divide by three through a scaled reciprocal
    min_cnt = CNT_W'(((side * side + 2) * 2731) >>> 13);
  end

  assign span_o = {1'(0), eff_r} << 1;

  // ring store and positions
  logic [PIX_W-1:0] mem [RING];
  logic [PIX_W-1:0] rdata_q;
  tag_e             tag_q;
  logic [AW-1:0]    wr_q, held_q, base_q, addr_q;
  logic [CW-1:0]    ocol_q;
  logic [FH_W-1:0]  orow_q;
  logic             last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem[wr_q] <= sample_i;
    rdata_q <= mem[addr_q];
  end

  logic [15:0] r16, w16, h16, c16, o16;
  logic        interior, at_last;
  logic [AW-1:0] base_c;

  always_comb begin
    r16      = 16'(eff_r);
    w16      = 16'(eff_w);
    h16      = 16'(eff_h);
    c16      = 16'(ocol_q);
    o16      = 16'(orow_q);
    interior = (o16 >= r16) && (o16 + r16 < h16) && (c16 >= r16) && (c16 + r16 < w16);
    at_last  = (o16 >= h16 - 16'd1) && (c16 >= w16 - 16'd1);
    base_c   = sub_mod(wr_q, held_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      held_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      tag_q  <= TAG_NONE;
    end else begin
      tag_q <= cmd_i.rd_tag;
      if (cmd_i.push) begin
        wr_q   <= add_mod(wr_q, AW'(1));
        held_q <= held_q + AW'(1);
      end else if (cmd_i.emit) begin
        held_q <= held_q - AW'(1);
        if (c16 + 16'd1 >= w16) begin
          ocol_q <= '0;
          orow_q <= (o16 + 16'd1 >= h16) ? '0 : orow_q + FH_W'(1);
        end else begin
          ocol_q <= ocol_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      base_q <= base_c;
      last_q <= at_last;
    end
    priority if (cmd_i.emit) begin
      addr_q <= base_c;
    end else begin
      unique case (cmd_i.addr_op)
        A_WIN:   addr_q <= sub_mod(base_q, lag);
        A_NBR:   addr_q <= sub_mod(base_q, AW'(eff_w) + AW'(1));
        A_STEP:  addr_q <= add_mod(addr_q, AW'(1));
        A_ROWW:  addr_q <= add_mod(addr_q, AW'(eff_w) - AW'(span_o));
        A_ROWN:  addr_q <= add_mod(addr_q, AW'(eff_w) - AW'(2));
        default: ;
      endcase
    end
  end

  // sums and divider
  logic [PIX_W-1:0] c_q;
  logic [SUM_W-1:0] total_q, quo_q;
  logic [CNT_W-1:0] count_q, rem_q;
  logic [11:0]      nsum_q;
  logic [8:0]       diff, adiff;
  logic             pick;
  logic [CNT_W:0]   trial;
  logic             ge;

  always_comb begin
    diff  = {1'b0, c_q} - {1'b0, rdata_q};
    adiff = diff[8] ? (9'd0 - diff) : diff;
    pick  = adiff < 9'(thr_q);
    trial = {rem_q, quo_q[SUM_W-1]};
    ge    = trial >= {1'b0, count_q};
  end

  always_ff @(posedge clk_i) begin
    unique case (tag_q)
      TAG_CTR: begin
        c_q     <= rdata_q;
        total_q <= '0;
        count_q <= '0;
      end
      TAG_WIN: begin
        if (pick) begin
          total_q <= total_q + SUM_W'(rdata_q);
          count_q <= count_q + CNT_W'(1);
        end
      end
      TAG_NBR:  nsum_q <= nsum_q + 12'(rdata_q);
      default: ;
    endcase
    if (cmd_i.nsum_init) nsum_q <= {1'b0, c_q, 3'b000} + 12'd8;
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= total_q;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? CNT_W'(trial - {1'b0, count_q}) : CNT_W'(trial);
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  // output register
  logic             ov_q;
  logic [PIX_W-1:0] opix_q;
  logic             olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.load_out) ov_q <= 1'b1;
    else if (!out_stall_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      olast_q <= last_q;
      unique case (cmd_i.res_sel)
        RES_C:   opix_q <= c_q;
        RES_N:   opix_q <= nsum_q[11:4];
        RES_D:   opix_q <= quo_q[PIX_W-1:0];
        default: opix_q <= c_q;
      endcase
    end
  end

  assign out_valid_o  = ov_q;
  assign pixel_out_o  = opix_q;
  assign frame_last_o = olast_q;

  assign sts_o.held_nz  = (held_q != '0);
  assign sts_o.full     = (held_q > lag);
  assign sts_o.interior = interior;
  assign sts_o.use_mean = (count_q > min_cnt);
  assign sts_o.out_free = !ov_q || !out_stall_i;

endmodule

@@ hdl/threshold_window_mean_filter.sv @@
// ----------------------------------------------------------------------------
// threshold_window_mean_filter
// Thresholded window-mean filter on one 8-bit plane in raster order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | sink      | in_valid_i / in_stall_o | in_op_i, in_sample_i
//  out     | source    | out_valid_o/out_stall_i | pixel_out_o, frame_last_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat at a time: a pixel with no result ends at the evaluate state; a border
// result returns the centre sample; a window result reads all (2R+1)^2 window
// samples from the line store, then runs the 3x3 fallback or the serial
// divider over SUM_W quotient bits (SUM_W = 17 at the default MAX_RADIUS). The
// single read port of the line store sets the window pass. Reset clears control
// state and restores the configuration defaults; the line store is not cleared.
// A stalled output holds in its register while the next input beat is taken.
// ----------------------------------------------------------------------------
module threshold_window_mean_filter #(
  parameter int MAX_WIDTH  = twm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = twm_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [twm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [twm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           in_op_i,
  input  logic [twm_pkg::PIX_W-1:0]      in_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [twm_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                           frame_last_o
);
  import twm_pkg::*;

  localparam int RW       = $clog2(MAX_RADIUS + 1);
  localparam int SW       = RW + 1;
  localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int SUM_W    = $clog2(255 * SIDE_MAX * SIDE_MAX + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [SW-1:0] span;

  // registers take a write on any cycle
  assign cfg_ready_o = 1'b1;

  twm_ctrl #(
    .SW        (SW),
    .DIV_N     (SUM_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_op_i   (in_op_i),
    .in_stall_o(in_stall_o),
    .span_i    (span),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  twm_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS),
    .SW        (SW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (in_sample_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .span_o      (span),
    .out_valid_o (out_valid_o),
    .pixel_out_o (pixel_out_o),
    .frame_last_o(frame_last_o)
  );

  // never overwrite a result still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

  // a result is only produced from a held pixel
  a_emit_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.held_nz)
    else $error("emit with empty line store");

  // a new output beat always comes from a load
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("output valid without load");

endmodule
